FILE: rtl/core/bspa_pkg.sv
// Shared constants and types for the bsdiff patch applier.
package bspa_pkg;

    // Patch phase codes
    localparam logic [2:0] PH_CONTROL = 3'd0;
    localparam logic [2:0] PH_DIFF    = 3'd1;
    localparam logic [2:0] PH_EXTRA   = 3'd2;
    localparam logic [2:0] PH_DONE    = 3'd3;
    localparam logic [2:0] PH_ERROR   = 3'd4;

    // Status codes on the result
    localparam logic [1:0] ST_RUN   = 2'd0;
    localparam logic [1:0] ST_DONE  = 2'd1;
    localparam logic [1:0] ST_ERROR = 2'd2;

    // Configuration register indexes
    localparam logic [1:0] CFG_OLD_SIZE = 2'd0;
    localparam logic [1:0] CFG_NEW_SIZE = 2'd1;

    // Control record: three 8-byte numbers
    localparam logic [4:0] CTL_DIFF_END  = 5'd8;
    localparam logic [4:0] CTL_EXTRA_END = 5'd16;
    localparam logic [4:0] CTL_SEEK_END  = 5'd24;

    // Lengths are limited to 31 bits
    localparam int LEN_W = 31;

    // Result flags
    typedef struct packed {
        logic       out_valid;
        logic       fetch_used;
        logic [1:0] status;
    } t_flags;

endpackage

FILE: rtl/core/bspa_in_reg.sv
// Input register holding one accepted patch item.
module bspa_in_reg (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_valid,
    output logic       o_ready,
    input  logic [7:0] i_patch_byte,
    input  logic [7:0] i_old_byte,
    input  logic       i_take,
    output logic       o_vld,
    output logic [7:0] o_patch_byte,
    output logic [7:0] o_old_byte
);

    logic       r_vld;
    logic [7:0] r_patch;
    logic [7:0] r_old;

    // Accept whenever the held item leaves this cycle or none is held
    assign o_ready = !r_vld || i_take;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= 1'b0;
        end else if (o_ready) begin
            r_vld <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_valid && o_ready) begin
            r_patch <= i_patch_byte;
            r_old   <= i_old_byte;
        end
    end

    assign o_vld        = r_vld;
    assign o_patch_byte = r_patch;
    assign o_old_byte   = r_old;

endmodule

FILE: rtl/core/bspa_core.sv
// Patch state and the single-pass per-item update.
module bspa_core #(
    parameter int SIZE_BITS = 24
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_step,
    input  logic [7:0]            i_patch_byte,
    input  logic [7:0]            i_old_byte,
    input  logic [SIZE_BITS-1:0]  i_old_size,
    input  logic [SIZE_BITS-1:0]  i_new_size,
    output bspa_pkg::t_flags      o_flags,
    output logic [7:0]            o_out_byte,
    output logic [SIZE_BITS-1:0]  o_out_offset,
    output logic [SIZE_BITS-1:0]  o_fetch_addr
);

    localparam int NP_W  = SIZE_BITS + 1;
    localparam int SUM_W = ((NP_W > bspa_pkg::LEN_W) ? NP_W : bspa_pkg::LEN_W) + 1;

    logic [2:0]                r_phase,  n_phase;
    logic [4:0]                r_cnt,    n_cnt;
    logic [63:0]               r_shift,  n_shift;
    logic [bspa_pkg::LEN_W-1:0] r_diff,  n_diff;
    logic [bspa_pkg::LEN_W-1:0] r_extra, n_extra;
    logic [63:0]               r_seek,   n_seek;
    logic [63:0]               r_oldp,   n_oldp;
    logic [NP_W-1:0]           r_newp,   n_newp;
    logic                      r_bad,    n_bad;

    logic [62:0] mag;
    logic        neg;
    logic        len_bad;
    logic        in_range;
    logic        in_range_post;
    logic [SUM_W-1:0] new_size_x;

    // Step logic: done test, one item, then the byte-free transitions
    always_comb begin
        n_phase = r_phase;
        n_cnt   = r_cnt;
        n_shift = r_shift;
        n_diff  = r_diff;
        n_extra = r_extra;
        n_seek  = r_seek;
        n_oldp  = r_oldp;
        n_newp  = r_newp;
        n_bad   = r_bad;

        o_flags    = '0;
        o_out_byte = '0;
        o_out_offset = '0;
        o_fetch_addr = '0;

        new_size_x = SUM_W'(i_new_size);
        in_range   = !r_oldp[63] && (r_oldp < 64'(i_old_size));
        mag        = '0;
        neg        = 1'b0;
        len_bad    = 1'b0;

        // Round start: new image complete means done (new_size may have moved)
        if (r_phase == bspa_pkg::PH_CONTROL && r_cnt == '0
            && r_newp >= NP_W'(i_new_size)) begin
            n_phase = bspa_pkg::PH_DONE;
        end

        unique case (n_phase)
            bspa_pkg::PH_CONTROL: begin
                n_shift = {i_patch_byte, r_shift[63:8]};
                n_cnt   = r_cnt + 5'd1;
                mag     = n_shift[62:0];
                neg     = n_shift[63];
                len_bad = (neg && mag != '0) || (mag[62:bspa_pkg::LEN_W] != '0);
                if (n_cnt == bspa_pkg::CTL_DIFF_END) begin
                    n_diff = len_bad ? '0 : mag[bspa_pkg::LEN_W-1:0];
                    n_bad  = r_bad || len_bad;
                end else if (n_cnt == bspa_pkg::CTL_EXTRA_END) begin
                    n_extra = len_bad ? '0 : mag[bspa_pkg::LEN_W-1:0];
                    n_bad   = r_bad || len_bad;
                end else if (n_cnt == bspa_pkg::CTL_SEEK_END) begin
                    n_seek = neg ? (64'd0 - {1'b0, mag}) : {1'b0, mag};
                    if (r_bad || (SUM_W'(r_newp) + SUM_W'(r_diff) > new_size_x)) begin
                        n_phase = bspa_pkg::PH_ERROR;
                    end else begin
                        n_phase = bspa_pkg::PH_DIFF;
                    end
                    n_bad = 1'b0;
                    n_cnt = '0;
                end
            end
            bspa_pkg::PH_DIFF: begin
                o_flags.out_valid = 1'b1;
                o_out_byte   = in_range ? (i_patch_byte + i_old_byte) : i_patch_byte;
                o_out_offset = r_newp[SIZE_BITS-1:0];
                n_newp = r_newp + NP_W'(1);
                n_oldp = r_oldp + 64'd1;
                n_diff = r_diff - bspa_pkg::LEN_W'(1);
            end
            bspa_pkg::PH_EXTRA: begin
                o_flags.out_valid = 1'b1;
                o_out_byte   = i_patch_byte;
                o_out_offset = r_newp[SIZE_BITS-1:0];
                n_newp  = r_newp + NP_W'(1);
                n_extra = r_extra - bspa_pkg::LEN_W'(1);
            end
            default: begin
            end
        endcase

        // End of diff run: extra must fit in the new image
        if (n_phase == bspa_pkg::PH_DIFF && n_diff == '0) begin
            if (SUM_W'(n_newp) + SUM_W'(n_extra) > new_size_x) begin
                n_phase = bspa_pkg::PH_ERROR;
            end else begin
                n_phase = bspa_pkg::PH_EXTRA;
            end
        end
        // End of extra run: apply seek, start a new round
        if (n_phase == bspa_pkg::PH_EXTRA && n_extra == '0) begin
            n_oldp  = n_oldp + n_seek;
            n_phase = bspa_pkg::PH_CONTROL;
            n_cnt   = '0;
        end
        if (n_phase == bspa_pkg::PH_CONTROL && n_cnt == '0
            && n_newp >= NP_W'(i_new_size)) begin
            n_phase = bspa_pkg::PH_DONE;
        end

        // Old-image fetch request for the following item
        in_range_post = !n_oldp[63] && (n_oldp < 64'(i_old_size));
        if (n_phase == bspa_pkg::PH_DIFF && in_range_post) begin
            o_flags.fetch_used = 1'b1;
            o_fetch_addr       = n_oldp[SIZE_BITS-1:0];
        end

        if (n_phase == bspa_pkg::PH_DONE) begin
            o_flags.status = bspa_pkg::ST_DONE;
        end else if (n_phase == bspa_pkg::PH_ERROR) begin
            o_flags.status = bspa_pkg::ST_ERROR;
        end else begin
            o_flags.status = bspa_pkg::ST_RUN;
        end
    end

    // State registers, advanced once per item
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= bspa_pkg::PH_CONTROL;
            r_cnt   <= '0;
            r_shift <= '0;
            r_diff  <= '0;
            r_extra <= '0;
            r_seek  <= '0;
            r_oldp  <= '0;
            r_newp  <= '0;
            r_bad   <= 1'b0;
        end else if (i_step) begin
            r_phase <= n_phase;
            r_cnt   <= n_cnt;
            r_shift <= n_shift;
            r_diff  <= n_diff;
            r_extra <= n_extra;
            r_seek  <= n_seek;
            r_oldp  <= n_oldp;
            r_newp  <= n_newp;
            r_bad   <= n_bad;
        end
    end

endmodule

FILE: rtl/core/bsdiff_patch_applier.sv
// Top level of the bsdiff patch applier: config registers, result register.
//
//  Channel  | Handshake                  | Payload
//  ---------+----------------------------+-----------------------------------------
//  patch in | i_in_valid / o_in_ready    | i_patch_byte, i_old_byte
//  result   | o_res_valid / i_res_ready  | o_out_valid, o_out_byte, o_out_offset,
//           |                            | o_old_fetch_addr, o_old_fetch_used, o_status
//  config   | i_cfg_valid / o_cfg_ready  | i_cfg_index, i_cfg_data
//
// One item per cycle sustained while results are taken; an accepted item passes through the
// input register, then the update into the result register.
// The per-item update is a 64-bit old-pointer add and a few length compares.
// Synchronous active-low reset clears all control state, the config registers and the valid bits of both registers.
// A stalled result holds; the input register keeps taking items while it can move.
module bsdiff_patch_applier #(
    parameter int SIZE_BITS = 24
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_in_valid,
    output logic                 o_in_ready,
    input  logic [7:0]           i_patch_byte,
    input  logic [7:0]           i_old_byte,
    output logic                 o_res_valid,
    input  logic                 i_res_ready,
    output logic                 o_out_valid,
    output logic [7:0]           o_out_byte,
    output logic [SIZE_BITS-1:0] o_out_offset,
    output logic [SIZE_BITS-1:0] o_old_fetch_addr,
    output logic                 o_old_fetch_used,
    output logic [1:0]           o_status,
    input  logic                 i_cfg_valid,
    output logic                 o_cfg_ready,
    input  logic [1:0]           i_cfg_index,
    input  logic [SIZE_BITS-1:0] i_cfg_data
);

    logic [SIZE_BITS-1:0] r_old_size;
    logic [SIZE_BITS-1:0] r_new_size;

    logic                 r_res_vld;
    bspa_pkg::t_flags     r_flags;
    logic [7:0]           r_byte;
    logic [SIZE_BITS-1:0] r_offset;
    logic [SIZE_BITS-1:0] r_fetch;

    logic                 adv;
    logic                 item_vld;
    logic [7:0]           item_patch;
    logic [7:0]           item_old;
    logic                 step;
    bspa_pkg::t_flags     c_flags;
    logic [7:0]           c_byte;
    logic [SIZE_BITS-1:0] c_offset;
    logic [SIZE_BITS-1:0] c_fetch;

    // Result register moves when empty or taken
    assign adv  = !r_res_vld || i_res_ready;
    assign step = item_vld && adv;

    bspa_in_reg u_in (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_valid      (i_in_valid),
        .o_ready      (o_in_ready),
        .i_patch_byte (i_patch_byte),
        .i_old_byte   (i_old_byte),
        .i_take       (adv),
        .o_vld        (item_vld),
        .o_patch_byte (item_patch),
        .o_old_byte   (item_old)
    );

    bspa_core #(
        .SIZE_BITS (SIZE_BITS)
    ) u_core (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_step       (step),
        .i_patch_byte (item_patch),
        .i_old_byte   (item_old),
        .i_old_size   (r_old_size),
        .i_new_size   (r_new_size),
        .o_flags      (c_flags),
        .o_out_byte   (c_byte),
        .o_out_offset (c_offset),
        .o_fetch_addr (c_fetch)
    );

    // Configuration registers; unknown indexes are dropped
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_old_size <= '0;
            r_new_size <= '0;
        end else if (i_cfg_valid) begin
            if (i_cfg_index == bspa_pkg::CFG_OLD_SIZE) begin
                r_old_size <= i_cfg_data;
            end else if (i_cfg_index == bspa_pkg::CFG_NEW_SIZE) begin
                r_new_size <= i_cfg_data;
            end
        end
    end

    // Result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_res_vld <= 1'b0;
        end else if (adv) begin
            r_res_vld <= item_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (step) begin
            r_flags  <= c_flags;
            r_byte   <= c_byte;
            r_offset <= c_offset;
            r_fetch  <= c_fetch;
        end
    end

    assign o_res_valid      = r_res_vld;
    assign o_out_valid      = r_flags.out_valid;
    assign o_out_byte       = r_byte;
    assign o_out_offset     = r_offset;
    assign o_old_fetch_addr = r_fetch;
    assign o_old_fetch_used = r_flags.fetch_used;
    assign o_status         = r_flags.status;

endmodule

FILE: tb/sv/bsdiff_patch_applier_tb.sv
// Self-checking testbench for the bsdiff patch applier: random patch streams checked per item.
module bsdiff_patch_applier_tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int SB = 24;
    localparam logic [SB-1:0] SIZE_MAX = '1;
    localparam logic [63:0] LEN_MAX = (64'd1 << bspa_pkg::LEN_W) - 64'd1;
    localparam logic [63:0] SIGN_BIT = 64'h8000_0000_0000_0000;
    localparam int IDLE_PCT = 26;
    localparam int RANDOM_ITEMS = 900;
    localparam int HOLD_AT = 300;
    localparam int STALL_LIMIT = 2000;
    localparam int SETTLE_CYCLES = 4;

    // How the patch stream is brought to its sticky end
    typedef enum int {
        END_NEW_ZERO,
        END_REACH_SIZE,
        END_NEG_DIFF,
        END_LONG_DIFF,
        END_BAD_EXTRA,
        END_DIFF_PAST,
        END_EXTRA_PAST
    } t_end_kind;

    typedef struct {
        logic [7:0] patch;
        logic [7:0] old;
        bit         hold;   // present only once every result is back
    } t_patch_item;

    typedef struct packed {
        logic          out_valid;
        logic [7:0]    out_byte;
        logic [SB-1:0] out_offset;
        logic [SB-1:0] fetch_addr;
        logic          fetch_used;
        logic [1:0]    status;
    } t_image_res;

    // Clock, reset and DUT ports
    logic          clk = 1'b0;
    logic          rst_n = 1'b0;
    logic          in_valid = 1'b0;
    logic          in_ready;
    logic [7:0]    in_patch = '0;
    logic [7:0]    in_old = '0;
    logic          res_valid;
    logic          res_ready = 1'b0;
    logic          out_valid;
    logic [7:0]    out_byte;
    logic [SB-1:0] out_offset;
    logic [SB-1:0] fetch_addr;
    logic          fetch_used;
    logic [1:0]    status;
    logic          cfg_valid = 1'b0;
    logic          cfg_ready;
    logic [1:0]    cfg_index = bspa_pkg::CFG_OLD_SIZE;
    logic [SB-1:0] cfg_data = '0;

    // Patch engine prediction state
    logic [2:0]  p_phase = bspa_pkg::PH_CONTROL;
    logic [4:0]  p_ctl_cnt = '0;
    logic [63:0] p_num = '0;
    logic [63:0] p_diff_left = '0;
    logic [63:0] p_extra_left = '0;
    logic [63:0] p_seek = '0;
    logic [63:0] p_old_ptr = '0;
    logic [63:0] p_new_ptr = '0;
    logic        p_ctl_bad = 1'b0;
    logic [63:0] p_old_size = '0;
    logic [63:0] p_new_size = '0;

    t_patch_item patch_stream_q[$];
    t_image_res  image_out_q[$];

    int            err_count = 0;
    int            item_count = 0;
    int            stall_cycles = 0;
    bit            steady = 1'b0;
    bit            drained = 1'b1;
    // Stimulus-side view of the pointers, used to aim seeks into the old image
    logic [63:0]   gen_old = '0;
    int            gen_new = 0;
    logic [SB-1:0] gen_old_size = '0;

    always begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    bsdiff_patch_applier #(
        .SIZE_BITS(SB)
    ) u_dut (
        .i_clk           (clk),
        .i_rst_n         (rst_n),
        .i_in_valid      (in_valid),
        .o_in_ready      (in_ready),
        .i_patch_byte    (in_patch),
        .i_old_byte      (in_old),
        .o_res_valid     (res_valid),
        .i_res_ready     (res_ready),
        .o_out_valid     (out_valid),
        .o_out_byte      (out_byte),
        .o_out_offset    (out_offset),
        .o_old_fetch_addr(fetch_addr),
        .o_old_fetch_used(fetch_used),
        .o_status        (status),
        .i_cfg_valid     (cfg_valid),
        .o_cfg_ready     (cfg_ready),
        .i_cfg_index     (cfg_index),
        .i_cfg_data      (cfg_data)
    );

    function automatic bit old_ptr_in_range();
        return !p_old_ptr[63] && p_old_ptr < p_old_size;
    endfunction

    // Phase moves that need no patch byte: end of diff, end of extra, done check
    function automatic void settle_phase();
        if (p_phase == bspa_pkg::PH_DIFF && p_diff_left == 64'd0) begin
            if (p_new_ptr + p_extra_left > p_new_size) begin
                p_phase = bspa_pkg::PH_ERROR;
                return;
            end
            p_phase = bspa_pkg::PH_EXTRA;
        end
        if (p_phase == bspa_pkg::PH_EXTRA && p_extra_left == 64'd0) begin
            p_old_ptr = p_old_ptr + p_seek;
            p_phase = bspa_pkg::PH_CONTROL;
            p_ctl_cnt = '0;
        end
        if (p_phase == bspa_pkg::PH_CONTROL && p_ctl_cnt == 5'd0
            && p_new_ptr >= p_new_size)
            p_phase = bspa_pkg::PH_DONE;
    endfunction

    // Advance the engine by one patch byte and return the result it gives
    function automatic t_image_res apply_patch_byte(logic [7:0] pb, logic [7:0] ob);
        t_image_res  r;
        logic [63:0] mag;
        logic        neg;
        r = '0;
        settle_phase();
        case (p_phase)
            bspa_pkg::PH_CONTROL: begin
                p_num = {pb, p_num[63:8]};
                p_ctl_cnt = p_ctl_cnt + 5'd1;
                if (p_ctl_cnt[2:0] == 3'd0) begin
                    mag = {1'b0, p_num[62:0]};
                    neg = p_num[63];
                    if (p_ctl_cnt == bspa_pkg::CTL_SEEK_END) begin
                        p_seek = neg ? 64'd0 - mag : mag;
                        if (p_ctl_bad || p_new_ptr + p_diff_left > p_new_size)
                            p_phase = bspa_pkg::PH_ERROR;
                        else
                            p_phase = bspa_pkg::PH_DIFF;
                        p_ctl_bad = 1'b0;
                        p_ctl_cnt = '0;
                    end else begin
                        // bad length is remembered and only faults after the seek field
                        if ((neg && mag != 64'd0) || mag > LEN_MAX) begin
                            p_ctl_bad = 1'b1;
                            mag = 64'd0;
                        end
                        if (p_ctl_cnt == bspa_pkg::CTL_DIFF_END)
                            p_diff_left = mag;
                        else
                            p_extra_left = mag;
                    end
                end
            end
            bspa_pkg::PH_DIFF: begin
                r.out_byte = old_ptr_in_range() ? pb + ob : pb;
                r.out_valid = 1'b1;
                r.out_offset = p_new_ptr[SB-1:0];
                p_new_ptr = p_new_ptr + 64'd1;
                p_old_ptr = p_old_ptr + 64'd1;
                p_diff_left = p_diff_left - 64'd1;
            end
            bspa_pkg::PH_EXTRA: begin
                r.out_byte = pb;
                r.out_valid = 1'b1;
                r.out_offset = p_new_ptr[SB-1:0];
                p_new_ptr = p_new_ptr + 64'd1;
                p_extra_left = p_extra_left - 64'd1;
            end
            default: ;
        endcase
        settle_phase();
        if (p_phase == bspa_pkg::PH_DIFF && old_ptr_in_range()) begin
            r.fetch_addr = p_old_ptr[SB-1:0];
            r.fetch_used = 1'b1;
        end
        if (p_phase == bspa_pkg::PH_DONE)
            r.status = bspa_pkg::ST_DONE;
        else if (p_phase == bspa_pkg::PH_ERROR)
            r.status = bspa_pkg::ST_ERROR;
        else
            r.status = bspa_pkg::ST_RUN;
        return r;
    endfunction

    // Sign-magnitude encoding of a control number
    function automatic logic [63:0] to_sign_mag(logic [63:0] v, bit neg_zero);
        logic [63:0] mag;
        mag = 64'd0 - v;
        if (v[63])
            return {1'b1, mag[62:0]};
        if (v == 64'd0 && neg_zero)
            return SIGN_BIT;
        return v;
    endfunction

    // Nonzero magnitude, optionally above the 31-bit length limit
    function automatic logic [63:0] rand_bad_mag(bit over_limit);
        logic [63:0] m;
        m = {1'b0, 31'($urandom), 32'($urandom)};
        if (over_limit) begin
            if (m <= LEN_MAX)
                m = m | (64'd1 << bspa_pkg::LEN_W);
        end else begin
            m = m >> $urandom_range(0, 62);
        end
        if (m == 64'd0)
            m = 64'd1;
        return m;
    endfunction

    task automatic push_item(input logic [7:0] patch, input logic [7:0] old);
        t_patch_item it;
        it.patch = patch;
        it.old = old;
        it.hold = (item_count == HOLD_AT) || ($urandom_range(0, 149) == 0);
        patch_stream_q.push_back(it);
        item_count++;
    endtask

    // Control record (little-endian words) followed by its data bytes
    task automatic push_record(input logic [63:0] diff_w, input logic [63:0] extra_w,
                               input logic [63:0] seek_w, input int n_data);
        logic [63:0] w[3];
        w[0] = diff_w;
        w[1] = extra_w;
        w[2] = seek_w;
        foreach (w[k])
            for (int b = 0; b < 8; b++)
                push_item(w[k][8*b +: 8], 8'($urandom));
        repeat (n_data) push_item(8'($urandom), 8'($urandom));
    endtask

    // Well-formed record within the remaining byte budget of this setting
    task automatic push_random_record(inout int budget);
        int          n_diff;
        int          n_extra;
        int          lim;
        logic [63:0] target;
        logic [63:0] delta;
        logic [63:0] seek_w;
        logic [63:0] seek_v;
        lim = budget < 24 ? budget : 24;
        n_diff = ($urandom_range(0, 5) == 0) ? 0 : $urandom_range(0, lim);
        lim = (budget - n_diff) < 24 ? budget - n_diff : 24;
        n_extra = ($urandom_range(0, 5) == 0) ? 0 : $urandom_range(0, lim);
        case ($urandom_range(0, 9))
            0: seek_w = {$urandom, $urandom};    // far jump, may wrap the pointer
            1: begin
                delta = $urandom_range(0, 32);
                seek_w = to_sign_mag(delta - 64'd16, $urandom_range(0, 1));
            end
            default: begin
                // land somewhere around the old image
                target = $urandom_range(0, gen_old_size + 2);
                seek_w = to_sign_mag(target - (gen_old + n_diff), $urandom_range(0, 1));
            end
        endcase
        seek_v = seek_w[63] ? 64'd0 - {1'b0, seek_w[62:0]} : {1'b0, seek_w[62:0]};
        gen_old = gen_old + n_diff + seek_v;
        gen_new = gen_new + n_diff + n_extra;
        budget = budget - n_diff - n_extra;
        push_record(to_sign_mag(n_diff, $urandom_range(0, 1)),
                    to_sign_mag(n_extra, $urandom_range(0, 1)), seek_w, n_diff + n_extra);
    endtask

    task automatic cfg_write(input logic [1:0] idx, input logic [SB-1:0] val);
        @(posedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        do @(posedge clk); while (!cfg_ready);
        cfg_valid <= 1'b0;
        if (idx == bspa_pkg::CFG_OLD_SIZE)
            p_old_size = val;
        else
            p_new_size = val;
        @(negedge clk);
    endtask

    // Wait until every item is in and every result is back
    task automatic wait_idle(input int extra_cycles);
        do @(negedge clk);
        while (patch_stream_q.size() != 0 || in_valid || image_out_q.size() != 0);
        repeat (extra_cycles) @(negedge clk);
    endtask

    task automatic check_field(input string name, input logic [63:0] want,
                               input logic [63:0] got);
        if (got !== want) begin
            err_count++;
            $error("%s: expected %0h, got %0h", name, want, got);
        end
    endtask

    always @(negedge clk) drained = (image_out_q.size() == 0);

    // Patch byte driver: predicts each item as it is taken
    always @(posedge clk) begin : patch_driver
        bit          fire;
        t_patch_item it;
        if (!rst_n) begin
            in_valid <= 1'b0;
        end else begin
            fire = in_valid && in_ready;
            if (fire)
                image_out_q.push_back(apply_patch_byte(in_patch, in_old));
            if (!in_valid || fire) begin
                if (patch_stream_q.size() != 0 && (steady || $urandom_range(0, 99) >= IDLE_PCT)
                    && (!patch_stream_q[0].hold || (drained && !fire))) begin
                    it = patch_stream_q.pop_front();
                    in_valid <= 1'b1;
                    in_patch <= it.patch;
                    in_old <= it.old;
                end else begin
                    in_valid <= 1'b0;
                end
            end
        end
    end

    // Result monitor with random back-pressure
    always @(posedge clk) begin : image_monitor
        t_image_res want;
        if (!rst_n) begin
            res_ready <= 1'b0;
        end else begin
            if (res_valid && res_ready) begin
                if (image_out_q.size() == 0) begin
                    err_count++;
                    $error("result with no item outstanding");
                end else begin
                    want = image_out_q.pop_front();
                    check_field("out_valid", want.out_valid, out_valid);
                    check_field("out_byte", want.out_byte, out_byte);
                    check_field("out_offset", want.out_offset, out_offset);
                    check_field("old_fetch_addr", want.fetch_addr, fetch_addr);
                    check_field("old_fetch_used", want.fetch_used, fetch_used);
                    check_field("status", want.status, status);
                end
            end
            res_ready <= steady || ($urandom_range(0, 99) >= IDLE_PCT);
        end
    end

    // Watchdog on cycles without any handshake
    always @(posedge clk) begin
        if ((in_valid && in_ready) || (res_valid && res_ready) || (cfg_valid && cfg_ready)) begin
            stall_cycles <= 0;
        end else if (stall_cycles >= STALL_LIMIT) begin
            $display("bsdiff_patch_applier_tb: FAIL");
            $finish;
        end else begin
            stall_cycles <= stall_cycles + 1;
        end
    end

    initial begin : stimulus
        int            budget;
        int            settings;
        logic [SB-1:0] new_lim;
        t_end_kind     fin;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;

        // Directed: 4-byte old image; diff of one byte where 0xFF + 0xFF wraps,
        // one extra byte, then a seek of -1 back to the start of the old image
        gen_old_size = SB'(4);
        cfg_write(bspa_pkg::CFG_OLD_SIZE, gen_old_size);
        cfg_write(bspa_pkg::CFG_NEW_SIZE, SIZE_MAX);
        push_record(64'd1, 64'd1, to_sign_mag(-64'sd1, 1'b0), 0);
        push_item(8'hFF, 8'hFF);
        push_item(8'h00, 8'hFF);
        gen_new = 2;

        // Random settings, each a run of well-formed records
        for (settings = 0; item_count < RANDOM_ITEMS + 26; settings++) begin
            wait_idle(SETTLE_CYCLES);
            steady = (settings == 2);
            case (settings)
                0: gen_old_size = '0;
                1: gen_old_size = SIZE_MAX;
                default: gen_old_size = ($urandom_range(0, 3) == 0) ?
                                        SB'($urandom) : SB'($urandom_range(1, 64));
            endcase
            cfg_write(bspa_pkg::CFG_OLD_SIZE, gen_old_size);
            budget = $urandom_range(60, 160);
            if (settings == 0) begin
                new_lim = SIZE_MAX;
            end else begin
                case ($urandom_range(0, 2))
                    0: new_lim = SIZE_MAX;
                    // one byte of slack: the last records just fit, no done yet
                    1: new_lim = SB'(gen_new + budget + 1);
                    default: new_lim = SB'($urandom_range(gen_new + budget + 1, SIZE_MAX));
                endcase
            end
            cfg_write(bspa_pkg::CFG_NEW_SIZE, new_lim);
            while (budget > 0)
                push_random_record(budget);
        end

        // Terminal case: done and error are sticky, so only one per run
        wait_idle(SETTLE_CYCLES);
        steady = 1'b0;
        fin = t_end_kind'($urandom_range(0, 6));
        case (fin)
            END_NEW_ZERO: cfg_write(bspa_pkg::CFG_NEW_SIZE, '0);
            END_REACH_SIZE: begin
                budget = $urandom_range(10, 40);
                cfg_write(bspa_pkg::CFG_NEW_SIZE, SB'(gen_new + budget));
                while (budget > 0)
                    push_random_record(budget);
            end
            END_NEG_DIFF: push_record(SIGN_BIT | rand_bad_mag(1'b0), 64'd0, 64'd0, 0);
            END_LONG_DIFF: push_record(rand_bad_mag(1'b1), 64'd0, 64'd0, 0);
            END_BAD_EXTRA: push_record(64'd2, $urandom_range(0, 1) ?
                                       (SIGN_BIT | rand_bad_mag(1'b0)) : rand_bad_mag(1'b1),
                                       64'd0, 0);
            END_DIFF_PAST: begin
                cfg_write(bspa_pkg::CFG_NEW_SIZE, SB'(gen_new + 5));
                push_record(64'd6, 64'd0, 64'd0, 0);
            end
            default: begin
                // extra overruns new_size, caught once the diff bytes are done
                cfg_write(bspa_pkg::CFG_NEW_SIZE, SB'(gen_new + 5));
                push_record(64'd3, 64'd3, 64'd0, 3);
            end
        endcase
        // bytes after the stop are ignored by the block
        repeat (24) push_item(8'($urandom), 8'($urandom));

        // leave room for a stray result
        wait_idle(SETTLE_CYCLES * 2);
        if (err_count == 0)
            $display("bsdiff_patch_applier_tb: PASS");
        else
            $display("bsdiff_patch_applier_tb: FAIL");
        $finish;
    end

endmodule
